@@ src/pms_pkg.sv @@
// Shared types and constants for the particle motion step block.
package pms_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TAG_W = 10;
  localparam int DT_W = 17;
  localparam int WORD_W = 32;
  localparam int ANG_W = 21;
  localparam int ANG_N = 3;
  localparam int SUMSQ_W = 64;
  localparam int DIST_W = SUMSQ_W / 2;
  localparam int ADDR_W = 4;
  localparam logic [DT_W-1:0] DT_RESET = 17'd1092;

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_CENTER_X  = 2'd1,
    REG_CENTER_Y  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TAG_W-1:0]         particle_tag;
    logic [63:0]              position_xy;
    logic [63:0]              velocity_xy;
    logic [63:0]              accel_xy;
    logic signed [31:0]       radial_accel;
    logic [31:0]              life_left;
    logic [31:0]              life_total;
    logic signed [31:0]       size_start;
    logic signed [31:0]       size_end;
    logic [ANG_N*ANG_W-1:0]   angle_xyz;
    logic [ANG_N*ANG_W-1:0]   spin_xyz;
    logic [ANG_N*ANG_W-1:0]   spin_accel_xyz;
  } in_t;

  typedef struct packed {
    logic [TAG_W-1:0]         tag_out;
    logic                     alive;
    logic [63:0]              new_position_xy;
    logic [63:0]              new_velocity_xy;
    logic [31:0]              new_life_left;
    logic signed [31:0]       size_now;
    logic [ANG_N*ANG_W-1:0]   new_angle_xyz;
    logic [ANG_N*ANG_W-1:0]   new_spin_xyz;
  } out_t;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic                     alive;
    logic [31:0]              nlife;
    logic [31:0]              total;
    logic [31:0]              ldiff;
    logic                     life_gt;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       vel_x;
    logic signed [31:0]       vel_y;
    logic signed [31:0]       acc_x;
    logic signed [31:0]       acc_y;
    logic signed [31:0]       radial;
    logic signed [31:0]       size0;
    logic signed [32:0]       sdiff;
    logic signed [31:0]       ds_x;
    logic signed [31:0]       ds_y;
    logic [31:0]              mag_x;
    logic [31:0]              mag_y;
    logic                     sgn_x;
    logic                     sgn_y;
    logic                     scaled;
    logic                     near;
    logic [31:0]              size;
    logic [ANG_N*ANG_W-1:0]   ang;
    logic [ANG_N*ANG_W-1:0]   spin;
  } ctx_t;

endpackage

@@ src/particle_motion_step.sv @@
// Top level: one semi-implicit Euler time step per particle, fully pipelined.
//
// Input channel (in_valid, in_ready, in_data) takes one particle state per
// transaction; the result channel (out_valid, out_ready, out_data) returns one
// updated particle per transaction, in order. An APB-style port sets the time
// step and the emission center; write it only while the block is idle.
// A new particle may enter in every cycle while the receiver does not stall, so
// the sustained rate is then one particle per clock. Between input transaction
// and result lie four front stages, a 32-stage square root for the distance,
// FRAC_BITS + 1 divider stages for the unit direction and life ratio, four
// back stages and the output register.
// When the receiver stalls, the whole pipeline holds and nothing is lost or
// repeated; the input register still takes a transaction if it is empty.
// Reset clears all valid bits and loads the time step with 1092 and the
// center with zero. Dead particles return only their tag, all else zero.
module particle_motion_step #(
  parameter int FRAC_BITS = pms_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pms_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pms_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pms_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import pms_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int QW = F + 1;
  localparam int NUMW = WORD_W + F;
  localparam int AP_W = ANG_W + DT_W + 1;
  localparam int WP_W = WORD_W + DT_W + 1;
  localparam int UR_W = F + 2 + WORD_W;
  localparam int SP_W = F + 2 + WORD_W + 1;
  localparam int RT_W = WORD_W + 2;
  localparam int RP_W = RT_W + DT_W + 1;
  localparam logic [WORD_W:0] MIN_DIST = (WORD_W + 1)'((1 << FRAC_BITS) / 1000);
  localparam logic signed [WORD_W:0] LIM = 33'sh0_8000_0000;

  // Configuration registers.
  logic [DT_W-1:0]          dt_r;
  logic signed [WORD_W-1:0] cx_r;
  logic signed [WORD_W-1:0] cy_r;
  logic                     cfg_wr;
  reg_idx_t                 widx;
  logic signed [DT_W:0]     dts;

  assign cfg_wr = psel & penable & pwrite;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign dts    = $signed({1'b0, dt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RESET;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_TIME_STEP: dt_r <= pwdata[DT_W-1:0];
        REG_CENTER_X:  cx_r <= pwdata;
        REG_CENTER_Y:  cy_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_TIME_STEP: prdata = {{(32-DT_W){1'b0}}, dt_r};
      REG_CENTER_X:  prdata = cx_r;
      REG_CENTER_Y:  prdata = cy_r;
      default:       prdata = '0;
    endcase
  end

  // Pipeline control.
  logic en;
  logic out_valid_r;
  out_t out_data_r;
  logic v0_r;
  in_t  p0_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en || !v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      p0_r <= in_data;
    end
  end

  // Stage 1: offsets from the center, life update, spin acceleration products.
  logic                   v1_r;
  ctx_t                   ctx1_nxt, ctx1_r;
  logic signed [AP_W-1:0] wadt_nxt [ANG_N];
  logic signed [AP_W-1:0] wadt1_r  [ANG_N];

  always_comb begin
    logic signed [WORD_W-1:0] px, py, s0, s1;
    logic signed [WORD_W:0]   dx, dy;
    logic signed [ANG_W-1:0]  wa;
    logic                     sc;
    px = p0_r.position_xy[63:32];
    py = p0_r.position_xy[31:0];
    s0 = p0_r.size_start;
    s1 = p0_r.size_end;
    dx = {cx_r[WORD_W-1], cx_r} - {px[WORD_W-1], px};
    dy = {cy_r[WORD_W-1], cy_r} - {py[WORD_W-1], py};
    sc = (dx >= LIM) || (dx <= -LIM) || (dy >= LIM) || (dy <= -LIM);
    ctx1_nxt         = '0;
    ctx1_nxt.tag     = p0_r.particle_tag;
    ctx1_nxt.alive   = p0_r.life_left > {{(32-DT_W){1'b0}}, dt_r};
    ctx1_nxt.nlife   = p0_r.life_left - {{(32-DT_W){1'b0}}, dt_r};
    ctx1_nxt.total   = p0_r.life_total;
    ctx1_nxt.pos_x   = px;
    ctx1_nxt.pos_y   = py;
    ctx1_nxt.vel_x   = p0_r.velocity_xy[63:32];
    ctx1_nxt.vel_y   = p0_r.velocity_xy[31:0];
    ctx1_nxt.acc_x   = p0_r.accel_xy[63:32];
    ctx1_nxt.acc_y   = p0_r.accel_xy[31:0];
    ctx1_nxt.radial  = p0_r.radial_accel;
    ctx1_nxt.size0   = s0;
    ctx1_nxt.sdiff   = {s1[WORD_W-1], s1} - {s0[WORD_W-1], s0};
    ctx1_nxt.scaled  = sc;
    ctx1_nxt.ds_x    = sc ? dx[WORD_W:1] : dx[WORD_W-1:0];
    ctx1_nxt.ds_y    = sc ? dy[WORD_W:1] : dy[WORD_W-1:0];
    ctx1_nxt.ang     = p0_r.angle_xyz;
    ctx1_nxt.spin    = p0_r.spin_xyz;
    for (int k = 0; k < ANG_N; k++) begin
      wa = $signed(p0_r.spin_accel_xyz[(ANG_N-1-k)*ANG_W +: ANG_W]);
      wadt_nxt[k] = wa * dts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r  <= ctx1_nxt;
      wadt1_r <= wadt_nxt;
    end
  end

  // Stage 2: squares, linear acceleration products, spin update.
  logic                     v2_r;
  ctx_t                     ctx2_nxt, ctx2_r;
  logic signed [2*WORD_W-1:0] sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  logic signed [WP_W-1:0]   axp_nxt, ayp_nxt, axp_r, ayp_r;
  logic signed [AP_W-1:0]   wp_nxt [ANG_N];
  logic signed [AP_W-1:0]   wp2_r  [ANG_N];

  always_comb begin
    logic signed [AP_W-1:0] sh;
    logic [ANG_W-1:0]       wn;
    ctx2_nxt         = ctx1_r;
    sqx_nxt          = ctx1_r.ds_x * ctx1_r.ds_x;
    sqy_nxt          = ctx1_r.ds_y * ctx1_r.ds_y;
    axp_nxt          = ctx1_r.acc_x * dts;
    ayp_nxt          = ctx1_r.acc_y * dts;
    ctx2_nxt.sgn_x   = ctx1_r.ds_x[WORD_W-1];
    ctx2_nxt.sgn_y   = ctx1_r.ds_y[WORD_W-1];
    ctx2_nxt.mag_x   = ctx1_r.ds_x[WORD_W-1] ? WORD_W'(-ctx1_r.ds_x) : ctx1_r.ds_x;
    ctx2_nxt.mag_y   = ctx1_r.ds_y[WORD_W-1] ? WORD_W'(-ctx1_r.ds_y) : ctx1_r.ds_y;
    ctx2_nxt.life_gt = ctx1_r.total > ctx1_r.nlife;
    ctx2_nxt.ldiff   = ctx1_r.total - ctx1_r.nlife;
    for (int k = 0; k < ANG_N; k++) begin
      sh = wadt1_r[k] >>> F;
      wn = ctx1_r.spin[(ANG_N-1-k)*ANG_W +: ANG_W] + sh[ANG_W-1:0];
      ctx2_nxt.spin[(ANG_N-1-k)*ANG_W +: ANG_W] = wn;
      wp_nxt[k] = $signed(wn) * dts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx2_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      axp_r  <= axp_nxt;
      ayp_r  <= ayp_nxt;
      wp2_r  <= wp_nxt;
    end
  end

  // Stage 3: sum of squares, scaled acceleration, angle update.
  logic               v3_r;
  ctx_t               ctx3_nxt, ctx3_r;
  logic [SUMSQ_W-1:0] sum_nxt, sum3_r;

  always_comb begin
    logic signed [AP_W-1:0] sh;
    logic signed [WP_W-1:0] ash, bsh;
    ctx3_nxt       = ctx2_r;
    sum_nxt        = SUMSQ_W'(sqx_r) + SUMSQ_W'(sqy_r);
    ash            = axp_r >>> F;
    bsh            = ayp_r >>> F;
    ctx3_nxt.acc_x = ash[WORD_W-1:0];
    ctx3_nxt.acc_y = bsh[WORD_W-1:0];
    for (int k = 0; k < ANG_N; k++) begin
      sh = wp2_r[k] >>> F;
      ctx3_nxt.ang[(ANG_N-1-k)*ANG_W +: ANG_W] =
        ctx2_r.ang[(ANG_N-1-k)*ANG_W +: ANG_W] + sh[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r <= ctx3_nxt;
      sum3_r <= sum_nxt;
    end
  end

  // Distance.
  logic [DIST_W-1:0] dist_len;
  logic              vs;
  ctx_t              ctxs;

  pms_isqrt #(.RAD_W(SUMSQ_W)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum3_r),
    .root (dist_len)
  );

  pms_delay #(.W($bits(ctx_t)), .DEPTH(DIST_W)) u_dly_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_data  (ctx3_r),
    .out_vld  (vs),
    .out_data (ctxs)
  );

  // Unit direction and life ratio.
  ctx_t          ctxp;
  logic [QW-1:0] qx, qy, qr;
  logic          vd;
  ctx_t          ctxd;

  always_comb begin
    ctxp      = ctxs;
    ctxp.near = ({1'b0, dist_len} << ctxs.scaled) > MIN_DIST;
  end

  pms_div #(.NUM_W(NUMW), .DEN_W(DIST_W), .Q_W(QW)) u_div_x (
    .clk (clk),
    .en  (en),
    .num ({ctxs.mag_x, {F{1'b0}}}),
    .den (dist_len),
    .quo (qx)
  );

  pms_div #(.NUM_W(NUMW), .DEN_W(DIST_W), .Q_W(QW)) u_div_y (
    .clk (clk),
    .en  (en),
    .num ({ctxs.mag_y, {F{1'b0}}}),
    .den (dist_len),
    .quo (qy)
  );

  pms_div #(.NUM_W(NUMW), .DEN_W(WORD_W), .Q_W(QW)) u_div_ratio (
    .clk (clk),
    .en  (en),
    .num ({ctxs.ldiff, {F{1'b0}}}),
    .den (ctxs.total),
    .quo (qr)
  );

  pms_delay #(.W($bits(ctx_t)), .DEPTH(QW)) u_dly_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vs),
    .in_data  (ctxp),
    .out_vld  (vd),
    .out_data (ctxd)
  );

  // Back stage 1: direction times radial acceleration, size slope times ratio.
  logic                   e1v_r;
  ctx_t                   ctxe1_r;
  logic signed [UR_W-1:0] urx_nxt, ury_nxt, urx_r, ury_r;
  logic signed [SP_W-1:0] sp_nxt, sp_r;

  always_comb begin
    logic signed [F+1:0] ux, uy, rs;
    ux      = ctxd.sgn_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    uy      = ctxd.sgn_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    rs      = ctxd.life_gt ? $signed({1'b0, qr}) : '0;
    urx_nxt = ux * ctxd.radial;
    ury_nxt = uy * ctxd.radial;
    sp_nxt  = ctxd.sdiff * rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1v_r <= 1'b0;
    end else if (en) begin
      e1v_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxe1_r <= ctxd;
      urx_r   <= urx_nxt;
      ury_r   <= ury_nxt;
      sp_r    <= sp_nxt;
    end
  end

  // Back stage 2: radial term times dt, interpolated size.
  logic                   e2v_r;
  ctx_t                   ctxe2_nxt, ctxe2_r;
  logic signed [RP_W-1:0] rpx_nxt, rpy_nxt, rpx_r, rpy_r;

  always_comb begin
    logic signed [UR_W-1:0] shx, shy;
    logic signed [SP_W-1:0] shs;
    logic signed [RT_W-1:0] tx, ty;
    shx            = urx_r >>> F;
    shy            = ury_r >>> F;
    shs            = sp_r >>> F;
    tx             = shx[RT_W-1:0];
    ty             = shy[RT_W-1:0];
    rpx_nxt        = tx * dts;
    rpy_nxt        = ty * dts;
    ctxe2_nxt      = ctxe1_r;
    ctxe2_nxt.size = ctxe1_r.size0 + shs[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2v_r <= 1'b0;
    end else if (en) begin
      e2v_r <= e1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxe2_r <= ctxe2_nxt;
      rpx_r   <= rpx_nxt;
      rpy_r   <= rpy_nxt;
    end
  end

  // Back stage 3: new velocity.
  logic e3v_r;
  ctx_t ctxe3_nxt, ctxe3_r;

  always_comb begin
    logic signed [RP_W-1:0] shx, shy;
    logic [WORD_W-1:0]      pullx, pully;
    shx             = rpx_r >>> F;
    shy             = rpy_r >>> F;
    pullx           = ctxe2_r.near ? shx[WORD_W-1:0] : '0;
    pully           = ctxe2_r.near ? shy[WORD_W-1:0] : '0;
    ctxe3_nxt       = ctxe2_r;
    ctxe3_nxt.vel_x = ctxe2_r.vel_x + pullx + ctxe2_r.acc_x;
    ctxe3_nxt.vel_y = ctxe2_r.vel_y + pully + ctxe2_r.acc_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3v_r <= 1'b0;
    end else if (en) begin
      e3v_r <= e2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxe3_r <= ctxe3_nxt;
    end
  end

  // Back stage 4: velocity times dt.
  logic                   e4v_r;
  ctx_t                   ctxe4_r;
  logic signed [WP_W-1:0] pvx_nxt, pvy_nxt, pvx_r, pvy_r;

  assign pvx_nxt = ctxe3_r.vel_x * dts;
  assign pvy_nxt = ctxe3_r.vel_y * dts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4v_r <= 1'b0;
    end else if (en) begin
      e4v_r <= e3v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxe4_r <= ctxe3_r;
      pvx_r   <= pvx_nxt;
      pvy_r   <= pvy_nxt;
    end
  end

  // Output register: new position and result assembly.
  out_t out_nxt;

  always_comb begin
    logic signed [WP_W-1:0] shx, shy;
    logic [WORD_W-1:0]      nx, ny;
    shx             = pvx_r >>> F;
    shy             = pvy_r >>> F;
    nx              = ctxe4_r.pos_x + shx[WORD_W-1:0];
    ny              = ctxe4_r.pos_y + shy[WORD_W-1:0];
    out_nxt         = '0;
    out_nxt.tag_out = ctxe4_r.tag;
    if (ctxe4_r.alive) begin
      out_nxt.alive           = 1'b1;
      out_nxt.new_position_xy = {nx, ny};
      out_nxt.new_velocity_xy = {ctxe4_r.vel_x, ctxe4_r.vel_y};
      out_nxt.new_life_left   = ctxe4_r.nlife;
      out_nxt.size_now        = ctxe4_r.size;
      out_nxt.new_angle_xyz   = ctxe4_r.ang;
      out_nxt.new_spin_xyz    = ctxe4_r.spin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e4v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.alive |->
      out_data_r.new_life_left == '0 && out_data_r.new_velocity_xy == '0)
    else $error("dead particle result carries nonzero fields");

  a_alive_life: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.alive |-> out_data_r.new_life_left != '0)
    else $error("live particle result has no remaining life");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v0_r)
    else $error("accepted transaction not captured in the input stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(e4v_r) && $stable(vd))
    else $error("pipeline valid changed during a stall");

endmodule

@@ src/pms_delay.sv @@
// Enabled delay line that carries a valid bit along with its data word.
module pms_delay #(
  parameter int W = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = data_r[DEPTH-1];

endmodule

@@ src/pms_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module pms_isqrt #(
  parameter int RAD_W = 64
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RAD_W-1:0]   rad,
  output logic [RAD_W/2-1:0] root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_in << 2;
        if (cur >= trial) begin
          rem_r[k]  <= REM_W'(cur - trial);
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= REM_W'(cur);
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

@@ src/pms_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
module pms_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int Q_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [Q_W-1:0]   lo_r  [Q_W];
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [Q_W-1:0]   lo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W:0]   cur;
    logic [DEN_W:0]   dd;

    if (k == 0) begin : g_first
      assign lo_in  = num[Q_W-1:0];
      assign rem_in = DEN_W'(num >> Q_W);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign lo_in  = lo_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign cur = {rem_in, lo_in[Q_W-1]};
    assign dd  = {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[k]  <= lo_in << 1;
        den_r[k] <= den_in;
        if (cur >= dd) begin
          rem_r[k] <= DEN_W'(cur - dd);
          quo_r[k] <= {quo_in[Q_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= DEN_W'(cur);
          quo_r[k] <= {quo_in[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

@@ tb/tb_top.sv @@
// Testbench for particle_motion_step: streams particles, predicts results and checks them.
class motion_scoreboard;
  localparam longint MIN_DIST = (64'sd1 <<< 16) / 1000;
  logic [16:0] dt = pms_pkg::DT_RESET;
  logic [31:0] cx = '0;
  logic [31:0] cy = '0;
  pms_pkg::out_t pending_q[$];
  int errors = 0;

  function longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function longint sx21(logic [20:0] v);
    return longint'(signed'(v));
  endfunction

  function longint scale_dt(longint a);
    return (a * longint'(dt)) >>> 16;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function void note_particle(pms_pkg::in_t d);
    pms_pkg::out_t o;
    logic [31:0] nlife, vx, vy;
    logic [20:0] a, w;
    longint px, py, dx, dy, ux, uy, ra, r, sz, lim;
    longint unsigned dist_len;
    int sc, sh;
    o = '0;
    o.tag_out = d.particle_tag;
    if (d.life_left > dt) begin
      nlife = d.life_left - dt;
      px = sx32(d.position_xy[63:32]);
      py = sx32(d.position_xy[31:0]);
      vx = d.velocity_xy[63:32];
      vy = d.velocity_xy[31:0];
      ra = sx32(d.radial_accel);
      dx = sx32(cx) - px;
      dy = sx32(cy) - py;
      lim = 64'sd1 <<< 31;
      sc = 0;
      if (dx >= lim || dx <= -lim || dy >= lim || dy <= -lim) begin
        dx = dx >>> 1;
        dy = dy >>> 1;
        sc = 1;
      end
      dist_len = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
      if (longint'(dist_len << sc) > MIN_DIST) begin
        ux = (dx * 65536) / longint'(dist_len);
        uy = (dy * 65536) / longint'(dist_len);
        vx = 32'(longint'(vx) + scale_dt((ux * ra) >>> 16));
        vy = 32'(longint'(vy) + scale_dt((uy * ra) >>> 16));
      end
      vx = 32'(longint'(vx) + scale_dt(sx32(d.accel_xy[63:32])));
      vy = 32'(longint'(vy) + scale_dt(sx32(d.accel_xy[31:0])));
      o.new_position_xy = {32'(px + scale_dt(sx32(vx))), 32'(py + scale_dt(sx32(vy)))};
      o.new_velocity_xy = {vx, vy};
      o.new_life_left = nlife;
      r = 0;
      if (d.life_total > nlife)
        r = longint'((64'(d.life_total - nlife) << 16) / 64'(d.life_total));
      sz = sx32(d.size_start) + (((sx32(d.size_end) - sx32(d.size_start)) * r) >>> 16);
      o.size_now = 32'(sz);
      for (int k = 0; k < 3; k++) begin
        sh = (2 - k) * 21;
        a = d.angle_xyz[sh +: 21];
        w = d.spin_xyz[sh +: 21];
        w = 21'(longint'(w) + scale_dt(sx21(d.spin_accel_xyz[sh +: 21])));
        a = 21'(longint'(a) + scale_dt(sx21(w)));
        o.new_angle_xyz[sh +: 21] = a;
        o.new_spin_xyz[sh +: 21] = w;
      end
      o.alive = 1'b1;
    end
    pending_q.push_back(o);
  endfunction

  function void compare(string name, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, e, g);
    end
  endfunction

  function void check_result(pms_pkg::out_t g);
    pms_pkg::out_t e;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t unexpected result expected none actual %h", $time, g);
      return;
    end
    e = pending_q.pop_front();
    compare("tag_out", e.tag_out, g.tag_out);
    compare("alive", e.alive, g.alive);
    compare("new_position_xy", e.new_position_xy, g.new_position_xy);
    compare("new_velocity_xy", e.new_velocity_xy, g.new_velocity_xy);
    compare("new_life_left", e.new_life_left, g.new_life_left);
    compare("size_now", e.size_now, g.size_now);
    compare("new_angle_xyz", e.new_angle_xyz, g.new_angle_xyz);
    compare("new_spin_xyz", e.new_spin_xyz, g.new_spin_xyz);
  endfunction
endclass

module tb_top;
  import pms_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int IN_W = $bits(in_t);

  logic clk = 0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  bit quiet = 0;
  bit long_hold = 0;
  int idle_cycles = 0;
  motion_scoreboard sb = new();

  particle_motion_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_particle(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_TIME_STEP: sb.dt = value[16:0];
      REG_CENTER_X: sb.cx = value;
      default: sb.cy = value;
    endcase
  endtask

  task automatic send_particle(in_t item, int gap);
    in_valid <= 1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [31:0] scaled_word();
    logic [31:0] v;
    v = $urandom;
    return 32'(signed'(v) >>> $urandom_range(0, 24));
  endfunction

  function automatic in_t random_particle();
    in_t d;
    int kind;
    kind = $urandom_range(0, 9);
    d.particle_tag = 10'($urandom);
    d.position_xy = {scaled_word(), scaled_word()};
    d.velocity_xy = {scaled_word(), scaled_word()};
    d.accel_xy = {scaled_word(), scaled_word()};
    d.radial_accel = scaled_word();
    d.size_start = scaled_word();
    d.size_end = scaled_word();
    d.angle_xyz = 63'({$urandom, $urandom});
    d.spin_xyz = 63'({$urandom, $urandom});
    d.spin_accel_xyz = 63'({$urandom, $urandom});
    d.life_total = $urandom;
    d.life_left = 32'(sb.dt) + 1 + $urandom_range(0, 32'h0040_0000);
    case (kind)
      0: d = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      1: d.life_left = $urandom_range(0, sb.dt);
      2: d.position_xy = {32'(sb.cx + $urandom_range(0, 90) - 45),
                          32'(sb.cy + $urandom_range(0, 90) - 45)};
      3: d.life_total = $urandom_range(0, 3) == 0 ? 0 : d.life_left - $urandom_range(0, 50);
      4: d.position_xy = {$urandom, $urandom};
      default: begin
        if (d.life_total < d.life_left) d.life_total = d.life_left + $urandom_range(0, 1000);
      end
    endcase
    return d;
  endfunction

  function automatic in_t directed_particle(int n);
    in_t d;
    d = '0;
    d.particle_tag = 10'(n);
    d.life_left = 32'h0002_0000;
    d.life_total = 32'h0004_0000;
    case (n)
      0: d = '0;
      1: d = '1;
      2: d.life_left = 32'(sb.dt);
      3: d.life_left = 32'(sb.dt) + 1;
      4: d.life_total = 0;
      5: d.life_total = 32'h0001_0000;
      6: d.position_xy = {32'h8000_0000, 32'h8000_0000};
      7: d.position_xy = {32'h7FFF_FFFF, 32'h8000_0000};
      8: begin
        d.position_xy = {32'h0000_0041, 32'h0};
        d.radial_accel = 32'h7FFF_FFFF;
      end
      9: begin
        d.position_xy = {32'h0000_0030, 32'h0000_0030};
        d.radial_accel = 32'h8000_0000;
      end
      10: begin
        d.velocity_xy = {32'h7FFF_FFFF, 32'h8000_0000};
        d.accel_xy = {32'h7FFF_FFFF, 32'h8000_0000};
      end
      11: begin
        d.size_start = 32'h8000_0000;
        d.size_end = 32'h7FFF_FFFF;
      end
      12: begin
        d.angle_xyz = {21'h0FFFFF, 21'h100000, 21'h1FFFFF};
        d.spin_xyz = {21'h0FFFFF, 21'h100000, 21'h1FFFFF};
        d.spin_accel_xyz = {21'h0FFFFF, 21'h100000, 21'h000001};
      end
      13: begin
        d.life_left = 32'hFFFF_FFFF;
        d.life_total = 32'hFFFF_FFFF;
      end
      14: d.life_left = 32'hFFFF_FFFF;
      15: begin
        d.position_xy = {32'hFFFF_0000, 32'h0001_0000};
        d.radial_accel = 32'h0010_0000;
        d.life_total = 32'h0002_1000;
      end
      default: d = random_particle();
    endcase
    return d;
  endfunction

  initial begin
    logic [31:0] dt_set[7];
    dt_set = '{0, 1, 65536, 131071, 1092, 4000, 30000};
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int n = 0; n < 20; n++) send_particle(directed_particle(n), $urandom_range(0, 2));
    in_valid <= 0;
    drain_pipeline();
    for (int p = 0; p < 7; p++) begin
      reg_write(REG_TIME_STEP, dt_set[p]);
      case (p % 4)
        0: begin
          reg_write(REG_CENTER_X, 32'h8000_0000);
          reg_write(REG_CENTER_Y, 32'h7FFF_FFFF);
        end
        1: begin
          reg_write(REG_CENTER_X, 32'h7FFF_FFFF);
          reg_write(REG_CENTER_Y, 32'h8000_0000);
        end
        2: begin
          reg_write(REG_CENTER_X, 0);
          reg_write(REG_CENTER_Y, 0);
        end
        default: begin
          reg_write(REG_CENTER_X, scaled_word());
          reg_write(REG_CENTER_Y, scaled_word());
        end
      endcase
      quiet = (p == 6);
      @(posedge clk);
      for (int n = 0; n < 262; n++) begin
        if (p == 2 && n == 40) long_hold = 1;
        send_particle(random_particle(),
                      (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0);
      end
      in_valid <= 0;
      drain_pipeline();
    end
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ particle_motion_step.f @@
src/pms_pkg.sv
src/pms_delay.sv
src/pms_isqrt.sv
src/pms_div.sv
src/particle_motion_step.sv
tb/tb_top.sv
